// File: hw/rtl/npi_pkg.sv
`timescale 1ns / 1ps
package npi_pkg;
    localparam int WORD_W = 32;
    localparam int STAT_W = 2;
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_DROP  = 2'd3;
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_EVAL   = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic load_pt;     // append input point
        logic load_q;      // capture query abscissa
        logic init_y;      // y <= ordinate of nearest
        logic scan_step;   // nearest-search over entry idx
        logic init_col;    // copy ordinate into c/d for entry idx
        logic calc_start;  // start tableau element (i, m)
        logic div_go;      // issue divisions
        logic write_cd;    // write quotients to c/d
        logic add_dy;      // finish column
        logic clear_out;   // zero y/dy
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic div_done;
    } t_sts;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[WORD_W-1:0];
    endfunction
endpackage

// File: hw/rtl/npi_if.sv
`timescale 1ns / 1ps
interface npi_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [npi_pkg::WORD_W-1:0] x_coord;
    logic signed [npi_pkg::WORD_W-1:0] y_value;
    modport source (output valid, func, x_coord, y_value, input ready);
    modport sink   (input valid, func, x_coord, y_value, output ready);
endinterface

interface npi_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [npi_pkg::WORD_W-1:0] interp_value;
    logic signed [npi_pkg::WORD_W-1:0] error_estimate;
    logic [npi_pkg::STAT_W-1:0]        status;
    modport source (output valid, interp_value, error_estimate, status, input ready);
    modport sink   (input valid, interp_value, error_estimate, status, output ready);
endinterface

// File: hw/rtl/npi_div.sv
`timescale 1ns / 1ps
// Restoring signed divider, one quotient bit per cycle, 66-bit dividend by 33-bit divisor.
module npi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  logic signed [65:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_done,
    output logic signed [65:0] o_quo
);
    logic [65:0] r_q;
    logic [66:0] r_rem;
    logic [32:0] r_d;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [66:0] w_sh;
    logic [66:0] w_sub;

    assign w_sh  = {r_rem[65:0], r_q[65]};
    assign w_sub = w_sh - {34'd0, r_d};
    assign o_done = r_busy && (r_cnt == 7'd0);
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= 7'd66;
            r_q    <= i_num[65] ? 66'(-i_num) : i_num;
            r_d    <= i_den[32] ? 33'(-i_den) : i_den;
            r_neg  <= i_num[65] ^ i_den[32];
            r_rem  <= '0;
        end else if (r_busy && r_cnt != 7'd0) begin
            r_cnt <= r_cnt - 7'd1;
            if (!w_sub[66]) begin
                r_rem <= w_sub;
                r_q   <= {r_q[64:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[64:0], 1'b0};
            end
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end
endmodule

// File: hw/rtl/npi_datapath.sv
`timescale 1ns / 1ps
module npi_datapath #(
    parameter int MAX_POINTS = 16,
    parameter int IDX_W      = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  npi_pkg::t_cmd        i_cmd,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [IDX_W-1:0]     i_jdx,
    input  logic [IDX_W-1:0]     i_dy_idx,
    input  logic                 i_dy_upper,
    input  logic signed [31:0]   i_x,
    input  logic signed [31:0]   i_y,
    output npi_pkg::t_sts        o_sts,
    output logic [IDX_W-1:0]     o_near,
    output logic signed [31:0]   o_interp,
    output logic signed [31:0]   o_err
);
    logic signed [31:0] r_xa [MAX_POINTS];
    logic signed [31:0] r_ya [MAX_POINTS];
    logic signed [31:0] r_c  [MAX_POINTS];
    logic signed [31:0] r_d  [MAX_POINTS];
    logic signed [31:0] r_yv, r_dy;
    logic signed [31:0] r_xq;
    logic [IDX_W-1:0]   r_near;
    logic [32:0]        r_best;
    logic signed [32:0] r_den;
    logic signed [65:0] r_p1, r_p2;
    logic signed [31:0] w_ho, w_hp, w_w;
    logic signed [32:0] w_diff;
    logic [32:0]        w_dist;
    logic               w_done1, w_done2;
    logic signed [65:0] w_q1, w_q2;

    assign w_diff = 33'(r_xq) - 33'(r_xa[i_idx]);
    assign w_dist = w_diff[32] ? 33'(-w_diff) : w_diff;
    assign w_ho   = npi_pkg::sat32(66'(r_xa[i_idx]) - 66'(r_xq));
    assign w_hp   = npi_pkg::sat32(66'(r_xa[i_jdx]) - 66'(r_xq));
    assign w_w    = npi_pkg::sat32(66'(r_c[i_idx + IDX_W'(1)]) - 66'(r_d[i_idx]));

    npi_div u_div_d (.i_clk, .i_rst_n, .i_go(i_cmd.div_go), .i_num(r_p1),
                     .i_den(r_den), .o_done(w_done1), .o_quo(w_q1));
    npi_div u_div_c (.i_clk, .i_rst_n, .i_go(i_cmd.div_go), .i_num(r_p2),
                     .i_den(r_den), .o_done(w_done2), .o_quo(w_q2));

    assign o_sts.den_zero = (r_den == '0);
    assign o_sts.div_done = w_done1 & w_done2;
    assign o_near   = r_near;
    assign o_interp = r_yv;
    assign o_err    = r_dy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            r_xa[i_idx] <= i_x;
            r_ya[i_idx] <= i_y;
        end
        if (i_cmd.load_q) begin
            r_xq <= i_x;
        end
        if (i_cmd.scan_step) begin
            if (i_idx == '0 || w_dist < r_best) begin
                r_best <= w_dist;
                r_near <= i_idx;
            end
        end
        if (i_cmd.init_col) begin
            r_c[i_idx] <= r_ya[i_idx];
            r_d[i_idx] <= r_ya[i_idx];
        end
        if (i_cmd.init_y) begin
            r_yv <= r_ya[r_near];
            r_dy <= '0;
        end
        if (i_cmd.calc_start) begin
            // one 32x32 multiply per product, divided over the next cycles
            r_p1  <= 66'(w_hp) * 66'(w_w);
            r_p2  <= 66'(w_ho) * 66'(w_w);
            r_den <= 33'(r_xa[i_idx]) - 33'(r_xa[i_jdx]);
        end
        if (i_cmd.write_cd) begin
            r_d[i_idx] <= npi_pkg::sat32(w_q1);
            r_c[i_idx] <= npi_pkg::sat32(w_q2);
        end
        if (i_cmd.add_dy) begin
            r_dy <= i_dy_upper ? r_c[i_dy_idx] : r_d[i_dy_idx];
            r_yv <= npi_pkg::sat32(66'(r_yv)
                    + 66'(i_dy_upper ? r_c[i_dy_idx] : r_d[i_dy_idx]));
        end
        if (i_cmd.clear_out) begin
            r_yv <= '0;
            r_dy <= '0;
        end
    end
endmodule

// File: hw/rtl/npi_ctrl.sv
`timescale 1ns / 1ps
module npi_ctrl #(
    parameter int MAX_POINTS = 16,
    parameter int IDX_W      = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_func,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [npi_pkg::STAT_W-1:0]  o_status,
    output npi_pkg::t_cmd               o_cmd,
    output logic [IDX_W-1:0]            o_idx,
    output logic [IDX_W-1:0]            o_jdx,
    output logic [IDX_W-1:0]            o_dy_idx,
    output logic                        o_dy_upper,
    input  npi_pkg::t_sts               i_sts,
    input  logic [IDX_W-1:0]            i_near
);
    localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_MUL = 3'd2,
                           S_DEN = 3'd3, S_DIV = 3'd4, S_COL = 3'd5,
                           S_OUT = 3'd6, S_NEAR = 3'd7;
    localparam int CNT_W = IDX_W + 1;
    localparam logic signed [CNT_W:0] POS_ONE = (CNT_W+1)'(1);

    logic [2:0]       r_st, n_st;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_i, n_i, r_m, n_m;
    logic signed [CNT_W:0] r_pos, n_pos;
    logic [npi_pkg::STAT_W-1:0] r_stat, n_stat;
    logic             w_in_fire;
    logic [CNT_W:0]   w_rows;

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = (r_st == S_OUT);
    assign o_status    = r_stat;
    assign w_in_fire   = i_in_valid && o_in_ready;
    // appends write at the fill count, the tableau walks r_i
    assign o_idx       = (r_st == S_IDLE) ? r_cnt[IDX_W-1:0] : r_i[IDX_W-1:0];
    assign o_jdx       = IDX_W'(r_i + r_m + CNT_W'(1));
    assign w_rows      = (CNT_W+1)'(r_cnt) - (CNT_W+1)'(r_m) - (CNT_W+1)'(1);
    assign o_dy_upper  = ($signed({1'b0, (CNT_W+1)'(2)}) * (r_pos + POS_ONE))
                         < $signed({1'b0, w_rows});
    assign o_dy_idx    = o_dy_upper ? IDX_W'(r_pos + POS_ONE) : IDX_W'(r_pos);

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_ovf = r_ovf; n_i = r_i; n_m = r_m;
        n_pos = r_pos; n_stat = r_stat;
        o_cmd = '0;
        case (r_st)
            S_IDLE: if (w_in_fire) begin
                if (i_in_func == npi_pkg::FUNC_APPEND) begin
                    if (r_cnt < CNT_W'(MAX_POINTS)) begin
                        o_cmd.load_pt = 1'b1;
                        n_cnt = r_cnt + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else if (r_cnt == '0) begin
                    n_stat = npi_pkg::ST_EMPTY;
                    o_cmd.clear_out = 1'b1;
                    n_st = S_OUT;
                end else begin
                    o_cmd.load_q = 1'b1;
                    n_i = '0;
                    n_stat = npi_pkg::ST_OK;
                    n_st = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.init_col  = 1'b1;
                n_i = r_i + CNT_W'(1);
                if (r_i + CNT_W'(1) == r_cnt) n_st = S_NEAR;
            end
            S_NEAR: begin
                o_cmd.init_y = 1'b1;
                n_pos = $signed({2'b0, i_near}) - POS_ONE;
                n_m = '0; n_i = '0;
                n_st = (r_cnt == CNT_W'(1)) ? S_OUT : S_MUL;
                if (r_cnt == CNT_W'(1) && r_ovf) n_stat = npi_pkg::ST_DROP;
            end
            S_MUL: begin
                o_cmd.calc_start = 1'b1;
                n_st = S_DEN;
            end
            S_DEN: begin
                if (i_sts.den_zero) begin
                    n_stat = npi_pkg::ST_DUP;
                    o_cmd.clear_out = 1'b1;
                    n_st = S_OUT;
                end else begin
                    o_cmd.div_go = 1'b1;
                    n_st = S_DIV;
                end
            end
            S_DIV: if (i_sts.div_done) begin
                o_cmd.write_cd = 1'b1;
                n_i = r_i + CNT_W'(1);
                n_st = ((CNT_W+1)'(r_i) + (CNT_W+1)'(1) == w_rows) ? S_COL : S_MUL;
            end
            S_COL: begin
                o_cmd.add_dy = 1'b1;
                if (!o_dy_upper) n_pos = r_pos - POS_ONE;
                n_i = '0;
                n_m = r_m + CNT_W'(1);
                if ((CNT_W+1)'(r_m) + (CNT_W+1)'(2) == (CNT_W+1)'(r_cnt)) begin
                    n_st = S_OUT;
                    if (r_ovf) n_stat = npi_pkg::ST_DROP;
                end else begin
                    n_st = S_MUL;
                end
            end
            S_OUT: if (i_out_ready) begin
                n_cnt = '0; n_ovf = 1'b0;
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_ovf <= 1'b0;
            r_i <= '0; r_m <= '0; r_pos <= '0; r_stat <= npi_pkg::ST_OK;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_ovf <= n_ovf;
            r_i <= n_i; r_m <= n_m; r_pos <= n_pos; r_stat <= n_stat;
        end
    end
endmodule

// File: hw/rtl/neville_polynomial_interpolator.sv
`timescale 1ns / 1ps
// Neville polynomial interpolator, signed fixed point (32-bit words). An append
// transfer (func 0) stores one sample point; once MAX_POINTS are held, further
// appends are dropped and the next result reports status 3, unless duplicate
// abscissae give status 1. An evaluate transfer (func 1) runs the tableau and
// yields one result: value, last correction and status (1 duplicate abscissae,
// 2 empty table); the table is then emptied. An evaluate over n points runs a
// nearest-sample search and then n(n-1)/2 tableau elements, each set by the
// bit-serial dividers (one quotient bit per cycle over 66 bits), with a
// correction added at the end of each column. One item is in work at a time.
module neville_polynomial_interpolator #(
    parameter int MAX_POINTS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    npi_in_if.sink    in_ch,
    npi_out_if.source out_ch
);
    // FRAC_BITS names the format only; the updates are scale-free.
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int FMT_FRAC = FRAC_BITS;

    npi_pkg::t_cmd    w_cmd;
    npi_pkg::t_sts    w_sts;
    logic [IDX_W-1:0] w_idx, w_jdx, w_dy_idx, w_near;
    logic             w_dy_upper;

    npi_ctrl #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .i_in_func(in_ch.func), .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .o_status(out_ch.status), .o_cmd(w_cmd), .o_idx(w_idx), .o_jdx(w_jdx),
        .o_dy_idx(w_dy_idx), .o_dy_upper(w_dy_upper), .i_sts(w_sts), .i_near(w_near)
    );

    npi_datapath #(.MAX_POINTS(MAX_POINTS), .IDX_W(IDX_W)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_idx(w_idx), .i_jdx(w_jdx),
        .i_dy_idx(w_dy_idx), .i_dy_upper(w_dy_upper),
        .i_x(in_ch.x_coord), .i_y(in_ch.y_value), .o_sts(w_sts), .o_near(w_near),
        .o_interp(out_ch.interp_value), .o_err(out_ch.error_estimate)
    );

    // accept no new transfer while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("input taken during result");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.status == npi_pkg::ST_EMPTY |->
        out_ch.interp_value == '0) else $error("empty table gave value");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.calc_start, w_cmd.div_go, w_cmd.write_cd, w_cmd.add_dy}))
        else $error("tableau commands overlap");
    a_fmt: assert property (@(posedge i_clk) FMT_FRAC >= 0) else $error("format");
endmodule
